// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WAVHP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WAVHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/wavhp_pkg.sv =====
package wavhp_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_payload;
  } out_t;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_ERROR   = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;

  typedef enum logic [3:0] {
    PH_RIFF_TAG  = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE_TAG  = 4'd2,
    PH_HDR_PRE   = 4'd3,
    PH_SKIP_PRE  = 4'd4,
    PH_FMT_LO    = 4'd5,
    PH_FMT_HI    = 4'd6,
    PH_FMT_EXTRA = 4'd7,
    PH_HDR_POST  = 4'd8,
    PH_SKIP_POST = 4'd9,
    PH_PAYLOAD   = 4'd10,
    PH_IDLE      = 4'd11
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BASE_LEN = 32'd16;
  localparam int          FMT_BYTES    = 16;

endpackage

// ===== rtl/wavhp_in_stage.sv =====
module wavhp_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_ready,
  input  wavhp_pkg::in_t  byte_item,
  input  logic            take,
  output logic            held_valid,
  output wavhp_pkg::in_t  held_item
);

  logic load;

  // Free when empty or when the held transaction leaves this cycle.
  assign byte_ready = !held_valid || take;
  assign load       = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= byte_item;
    end
  end

endmodule

// ===== rtl/wavhp_parser.sv =====
`include "assert_macros.svh"

module wavhp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             held_valid,
  input  wavhp_pkg::in_t   held_item,
  input  logic             slot_free,
  output logic             take,
  output logic             push,
  output wavhp_pkg::out_t  res
);

  wavhp_pkg::phase_t phase, phase_next, cur_phase;
  logic [2:0]  idx, idx_next, cur_idx;
  logic [31:0] tag, tag_next, cur_tag;
  logic [31:0] sacc, sacc_next, cur_sacc;
  logic [31:0] skip, skip_next, cur_skip;
  logic [31:0] drem, drem_next, cur_drem;
  logic [7:0]  fmt [wavhp_pkg::FMT_BYTES];
  logic        fmt_we;
  logic [3:0]  fmt_addr;
  logic        has_result;
  logic [7:0]  b;
  logic [31:0] tag_sh;
  logic [31:0] sacc_full;
  logic        hdr_done;

  assign b = held_item.in_byte;

  // Start of file restarts the parse from the cleared state.
  always_comb begin
    if (held_item.start_of_file) begin
      cur_phase = wavhp_pkg::PH_RIFF_TAG;
      cur_idx   = '0;
      cur_tag   = '0;
      cur_sacc  = '0;
      cur_skip  = '0;
      cur_drem  = '0;
    end else begin
      cur_phase = phase;
      cur_idx   = idx;
      cur_tag   = tag;
      cur_sacc  = sacc;
      cur_skip  = skip;
      cur_drem  = drem;
    end
  end

  assign tag_sh   = {cur_tag[23:0], b};
  assign hdr_done = (cur_idx == 3'd7);

  // Size bytes arrive little-endian into the lane picked by the index.
  always_comb begin
    sacc_full = cur_sacc;
    case (cur_idx[1:0])
      2'd0:    sacc_full[7:0]   = cur_sacc[7:0]   | b;
      2'd1:    sacc_full[15:8]  = cur_sacc[15:8]  | b;
      2'd2:    sacc_full[23:16] = cur_sacc[23:16] | b;
      default: sacc_full[31:24] = cur_sacc[31:24] | b;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_next = cur_phase;
    idx_next   = cur_idx;
    tag_next   = cur_tag;
    sacc_next  = cur_sacc;
    skip_next  = cur_skip;
    drem_next  = cur_drem;
    unique case (cur_phase)
      wavhp_pkg::PH_RIFF_TAG, wavhp_pkg::PH_WAVE_TAG: begin
        tag_next = tag_sh;
        idx_next = cur_idx + 3'd1;
        if (cur_idx == 3'd3) begin
          idx_next = '0;
          if (cur_phase == wavhp_pkg::PH_RIFF_TAG) begin
            if (tag_sh != wavhp_pkg::TAG_RIFF) begin
              phase_next = wavhp_pkg::PH_IDLE;
            end else begin
              phase_next = wavhp_pkg::PH_RIFF_SIZE;
              tag_next   = '0;
            end
          end else begin
            if (tag_sh != wavhp_pkg::TAG_WAVE) begin
              phase_next = wavhp_pkg::PH_IDLE;
            end else begin
              phase_next = wavhp_pkg::PH_HDR_PRE;
              tag_next   = '0;
            end
          end
        end
      end
      wavhp_pkg::PH_RIFF_SIZE: begin
        idx_next = cur_idx + 3'd1;
        if (cur_idx == 3'd3) begin
          idx_next   = '0;
          phase_next = wavhp_pkg::PH_WAVE_TAG;
        end
      end
      wavhp_pkg::PH_HDR_PRE, wavhp_pkg::PH_HDR_POST: begin
        idx_next = cur_idx + 3'd1;
        if (!cur_idx[2]) begin
          tag_next = tag_sh;
        end else begin
          sacc_next = sacc_full;
        end
        if (hdr_done) begin
          tag_next  = '0;
          sacc_next = '0;
          if (cur_phase == wavhp_pkg::PH_HDR_PRE) begin
            if (cur_tag == wavhp_pkg::TAG_FMT) begin
              skip_next  = (sacc_full > wavhp_pkg::FMT_BASE_LEN) ?
                           sacc_full - wavhp_pkg::FMT_BASE_LEN : '0;
              phase_next = wavhp_pkg::PH_FMT_LO;
            end else begin
              skip_next  = sacc_full;
              phase_next = (sacc_full != '0) ? wavhp_pkg::PH_SKIP_PRE
                                             : wavhp_pkg::PH_HDR_PRE;
            end
          end else begin
            if (cur_tag == wavhp_pkg::TAG_DATA) begin
              drem_next  = sacc_full;
              phase_next = (sacc_full != '0) ? wavhp_pkg::PH_PAYLOAD
                                             : wavhp_pkg::PH_IDLE;
            end else begin
              skip_next  = sacc_full;
              phase_next = (sacc_full != '0) ? wavhp_pkg::PH_SKIP_POST
                                             : wavhp_pkg::PH_HDR_POST;
            end
          end
        end
      end
      wavhp_pkg::PH_SKIP_PRE, wavhp_pkg::PH_SKIP_POST, wavhp_pkg::PH_FMT_EXTRA: begin
        if (cur_skip != '0) begin
          skip_next = cur_skip - 32'd1;
        end
        if (cur_skip <= 32'd1) begin
          phase_next = (cur_phase == wavhp_pkg::PH_SKIP_PRE) ? wavhp_pkg::PH_HDR_PRE
                                                             : wavhp_pkg::PH_HDR_POST;
        end
      end
      wavhp_pkg::PH_FMT_LO, wavhp_pkg::PH_FMT_HI: begin
        idx_next = cur_idx + 3'd1;
        if (hdr_done) begin
          if (cur_phase == wavhp_pkg::PH_FMT_LO) begin
            phase_next = wavhp_pkg::PH_FMT_HI;
          end else begin
            phase_next = (cur_skip != '0) ? wavhp_pkg::PH_FMT_EXTRA
                                          : wavhp_pkg::PH_HDR_POST;
          end
        end
      end
      wavhp_pkg::PH_PAYLOAD: begin
        if (cur_drem != '0) begin
          drem_next = cur_drem - 32'd1;
        end
        if (cur_drem <= 32'd1) begin
          phase_next = wavhp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = cur_phase;
      end
    endcase
  end

  // Output logic: result decode and fmt byte write.
  always_comb begin
    res        = '0;
    has_result = 1'b0;
    fmt_we     = 1'b0;
    fmt_addr   = {cur_phase == wavhp_pkg::PH_FMT_HI, cur_idx};
    unique case (cur_phase)
      wavhp_pkg::PH_RIFF_TAG: begin
        if (cur_idx == 3'd3 && tag_sh != wavhp_pkg::TAG_RIFF) begin
          has_result      = 1'b1;
          res.result_kind = wavhp_pkg::KIND_ERROR;
        end
      end
      wavhp_pkg::PH_WAVE_TAG: begin
        if (cur_idx == 3'd3 && tag_sh != wavhp_pkg::TAG_WAVE) begin
          has_result      = 1'b1;
          res.result_kind = wavhp_pkg::KIND_ERROR;
        end
      end
      wavhp_pkg::PH_FMT_LO, wavhp_pkg::PH_FMT_HI: begin
        fmt_we = 1'b1;
      end
      wavhp_pkg::PH_HDR_POST: begin
        if (hdr_done && cur_tag == wavhp_pkg::TAG_DATA) begin
          has_result         = 1'b1;
          res.result_kind    = wavhp_pkg::KIND_HEADER;
          res.audio_format   = {fmt[1], fmt[0]};
          res.channel_count  = {fmt[3], fmt[2]};
          res.sample_rate    = {fmt[7], fmt[6], fmt[5], fmt[4]};
          res.byte_rate      = {fmt[11], fmt[10], fmt[9], fmt[8]};
          res.block_align    = {fmt[13], fmt[12]};
          res.sample_bits    = {fmt[15], fmt[14]};
          res.payload_length = sacc_full;
        end
      end
      wavhp_pkg::PH_PAYLOAD: begin
        has_result       = 1'b1;
        res.result_kind  = wavhp_pkg::KIND_PAYLOAD;
        res.payload_byte = b;
        res.last_payload = (cur_drem <= 32'd1);
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // Items without a result never wait on the output side.
  assign take = held_valid && (!has_result || slot_free);
  assign push = take && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wavhp_pkg::PH_RIFF_TAG;
      idx   <= '0;
      tag   <= '0;
      sacc  <= '0;
      skip  <= '0;
      drem  <= '0;
    end else if (take) begin
      phase <= phase_next;
      idx   <= idx_next;
      tag   <= tag_next;
      sacc  <= sacc_next;
      skip  <= skip_next;
      drem  <= drem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fmt_we) begin
      fmt[fmt_addr] <= b;
    end
  end

  `WAVHP_ASSERT_NEXT(a_error_parks, clk, rst,
    push && res.result_kind == wavhp_pkg::KIND_ERROR, phase == wavhp_pkg::PH_IDLE)
  `WAVHP_ASSERT_NEXT(a_last_parks, clk, rst,
    push && res.result_kind == wavhp_pkg::KIND_PAYLOAD && res.last_payload,
    phase == wavhp_pkg::PH_IDLE)
  `WAVHP_ASSERT_NOW(a_tag_index, clk, rst,
    phase == wavhp_pkg::PH_RIFF_TAG || phase == wavhp_pkg::PH_WAVE_TAG ||
    phase == wavhp_pkg::PH_RIFF_SIZE, !idx[2])

endmodule

// ===== rtl/wavhp_out_stage.sv =====
module wavhp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wavhp_pkg::out_t  res,
  output logic             slot_free,
  output logic             result_valid,
  input  logic             result_ready,
  output wavhp_pkg::out_t  result_item
);

  // Accept a new result when empty or when the waiting one is taken now.
  assign slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_item <= res;
    end
  end

endmodule

// ===== rtl/wav_header_parser_top.sv =====
// RIFF/WAVE header parser. Feed the file one byte per transaction, raising
// start_of_file on its first byte; the parser checks the RIFF and WAVE tags,
// skips unknown chunks by their stated size (no pad byte), captures the first
// 16 bytes of the fmt chunk and, at the data chunk header, returns one header
// result followed by one payload result per data byte, the final one flagged
// with last_payload. A bad tag returns a single error result, after which
// bytes are dropped until the next start_of_file. Throughput is one byte per
// clock cycle while no result byte waits on a full output register: the byte
// sits in an input register, one parse step updates the small counters and
// shift registers, and any result lands in an output register at the clock
// edge at which the parse step takes its byte from the input register.
// Bytes that produce no result keep flowing while a result waits at the
// output; a byte that produces one is held until the output register frees.
// Fields that do not belong to a result's kind are zero.
module wav_header_parser_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  wavhp_pkg::in_t   byte_item,
  output logic             result_valid,
  input  logic             result_ready,
  output wavhp_pkg::out_t  result_item
);

  logic            held_valid;
  wavhp_pkg::in_t  held_item;
  logic            take;
  logic            push;
  logic            slot_free;
  wavhp_pkg::out_t res;

  // Input register: hold one incoming transaction for the parse step.
  wavhp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Parse step: advance the phase and counters, decode any result.
  wavhp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_item  (held_item),
    .slot_free  (slot_free),
    .take       (take),
    .push       (push),
    .res        (res)
  );

  // Result register: hold a result until the consumer takes it.
  wavhp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .res          (res),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

// ===== tb/wav_header_parser_top_tb.sv =====
module wav_header_parser_top_tb;

  // Chunk ids that the parser never looks for, and corrupted versions of the two it checks
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
  localparam logic [31:0] TAG_JUNK = 32'h6A75_6E6B;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;
  localparam logic [31:0] TAG_WAVF = 32'h5741_5646;

  // Generous cap: roughly 1300 bytes, each waiting out long gaps and stalls, many times over
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  logic             clk;
  logic             rst;
  logic             byte_valid;
  logic             byte_ready;
  wavhp_pkg::in_t   byte_item;
  logic             result_valid;
  logic             result_ready;
  wavhp_pkg::out_t  result_item;

  // Parser image kept by the testbench
  wavhp_pkg::phase_t cur_phase;
  logic [2:0]  byte_idx;
  logic [31:0] tag_reg;
  logic [31:0] len_reg;
  logic [31:0] skip_count;
  logic [31:0] payload_left;
  logic [7:0]  fmt_raw [16];

  wavhp_pkg::out_t parsed_results_due [$];
  logic [7:0]      file_bytes [$];

  int send_idle_pct;
  int stall_pct;
  int mismatch_count;
  int cycle_count;
  int bytes_parsed;
  int files_sent;
  int header_seen;
  int error_seen;
  int payload_seen;

  wav_header_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               parsed_results_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser prediction
  // ---------------------------------------------------------------------------

  task automatic clear_parser();
    cur_phase    = wavhp_pkg::PH_RIFF_TAG;
    byte_idx     = '0;
    tag_reg      = '0;
    len_reg      = '0;
    skip_count   = '0;
    payload_left = '0;
    foreach (fmt_raw[k]) fmt_raw[k] = '0;
  endtask

  // Shift one chunk-header byte in: id big-endian first, then the size little-endian.
  // Return 1 on the eighth byte.
  function automatic bit header_byte_done(input logic [7:0] b);
    int i;
    i = byte_idx;
    if (i < 4) tag_reg = {tag_reg[23:0], b};
    else len_reg |= 32'(b) << (8 * (i - 4));
    byte_idx = byte_idx + 3'd1;
    return i == 7;
  endfunction

  // Advance the parser image by one accepted byte and queue any result it yields
  task automatic parse_wave_byte(input wavhp_pkg::in_t item);
    wavhp_pkg::out_t r;
    logic [7:0]      b;
    logic [31:0]     want_tag;
    b = item.in_byte;
    r = '0;
    if (item.start_of_file) clear_parser();
    if (cur_phase != wavhp_pkg::PH_IDLE) bytes_parsed++;
    case (cur_phase)
      wavhp_pkg::PH_RIFF_TAG, wavhp_pkg::PH_WAVE_TAG: begin
        tag_reg  = {tag_reg[23:0], b};
        byte_idx = byte_idx + 3'd1;
        if (byte_idx == 3'd4) begin
          want_tag = (cur_phase == wavhp_pkg::PH_RIFF_TAG) ? wavhp_pkg::TAG_RIFF
                                                           : wavhp_pkg::TAG_WAVE;
          byte_idx = '0;
          if (tag_reg != want_tag) begin
            // a bad tag gives one error, then the stream is dead until restart
            cur_phase = wavhp_pkg::PH_IDLE;
            r.result_kind = wavhp_pkg::KIND_ERROR;
            parsed_results_due.push_back(r);
          end else begin
            if (cur_phase == wavhp_pkg::PH_RIFF_TAG) cur_phase = wavhp_pkg::PH_RIFF_SIZE;
            else cur_phase = wavhp_pkg::PH_HDR_PRE;
            tag_reg = '0;
          end
        end
      end
      wavhp_pkg::PH_RIFF_SIZE: begin
        byte_idx = byte_idx + 3'd1;
        if (byte_idx == 3'd4) begin
          byte_idx  = '0;
          cur_phase = wavhp_pkg::PH_WAVE_TAG;
        end
      end
      wavhp_pkg::PH_HDR_PRE: begin
        if (header_byte_done(b)) begin
          if (tag_reg == wavhp_pkg::TAG_FMT) begin
            // only bytes past the first sixteen are skipped; a short fmt still takes 16
            skip_count = (len_reg > wavhp_pkg::FMT_BASE_LEN) ?
                         len_reg - wavhp_pkg::FMT_BASE_LEN : '0;
            cur_phase  = wavhp_pkg::PH_FMT_LO;
          end else begin
            skip_count = len_reg;
            cur_phase  = (len_reg != 0) ? wavhp_pkg::PH_SKIP_PRE : wavhp_pkg::PH_HDR_PRE;
          end
          tag_reg = '0;
          len_reg = '0;
        end
      end
      wavhp_pkg::PH_SKIP_PRE, wavhp_pkg::PH_SKIP_POST, wavhp_pkg::PH_FMT_EXTRA: begin
        if (skip_count != 0) skip_count--;
        if (skip_count == 0) begin
          if (cur_phase == wavhp_pkg::PH_SKIP_PRE) cur_phase = wavhp_pkg::PH_HDR_PRE;
          else cur_phase = wavhp_pkg::PH_HDR_POST;
        end
      end
      wavhp_pkg::PH_FMT_LO, wavhp_pkg::PH_FMT_HI: begin
        fmt_raw[{cur_phase == wavhp_pkg::PH_FMT_HI, byte_idx}] = b;
        if (byte_idx == 3'd7) begin
          if (cur_phase == wavhp_pkg::PH_FMT_LO) cur_phase = wavhp_pkg::PH_FMT_HI;
          else if (skip_count != 0) cur_phase = wavhp_pkg::PH_FMT_EXTRA;
          else cur_phase = wavhp_pkg::PH_HDR_POST;
        end
        byte_idx = byte_idx + 3'd1;
      end
      wavhp_pkg::PH_HDR_POST: begin
        if (header_byte_done(b)) begin
          if (tag_reg == wavhp_pkg::TAG_DATA) begin
            payload_left     = len_reg;
            cur_phase        = (len_reg != 0) ? wavhp_pkg::PH_PAYLOAD : wavhp_pkg::PH_IDLE;
            r.result_kind    = wavhp_pkg::KIND_HEADER;
            r.audio_format   = {fmt_raw[1], fmt_raw[0]};
            r.channel_count  = {fmt_raw[3], fmt_raw[2]};
            r.sample_rate    = {fmt_raw[7], fmt_raw[6], fmt_raw[5], fmt_raw[4]};
            r.byte_rate      = {fmt_raw[11], fmt_raw[10], fmt_raw[9], fmt_raw[8]};
            r.block_align    = {fmt_raw[13], fmt_raw[12]};
            r.sample_bits    = {fmt_raw[15], fmt_raw[14]};
            r.payload_length = len_reg;
            parsed_results_due.push_back(r);
          end else begin
            skip_count = len_reg;
            cur_phase  = (len_reg != 0) ? wavhp_pkg::PH_SKIP_POST : wavhp_pkg::PH_HDR_POST;
          end
          tag_reg = '0;
          len_reg = '0;
        end
      end
      wavhp_pkg::PH_PAYLOAD: begin
        if (payload_left != 0) payload_left--;
        r.result_kind  = wavhp_pkg::KIND_PAYLOAD;
        r.payload_byte = b;
        r.last_payload = (payload_left == 0);
        parsed_results_due.push_back(r);
        if (payload_left == 0) cur_phase = wavhp_pkg::PH_IDLE;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  task automatic compare_result(input wavhp_pkg::out_t got);
    wavhp_pkg::out_t want;
    if (parsed_results_due.size() == 0) begin
      report_mismatch($sformatf("result kind %0d arrived with nothing pending", got.result_kind));
    end else begin
      want = parsed_results_due.pop_front();
      check_field("result_kind", got.result_kind, want.result_kind);
      check_field("audio_format", got.audio_format, want.audio_format);
      check_field("channel_count", got.channel_count, want.channel_count);
      check_field("sample_rate", got.sample_rate, want.sample_rate);
      check_field("byte_rate", got.byte_rate, want.byte_rate);
      check_field("block_align", got.block_align, want.block_align);
      check_field("sample_bits", got.sample_bits, want.sample_bits);
      check_field("payload_length", got.payload_length, want.payload_length);
      check_field("payload_byte", got.payload_byte, want.payload_byte);
      check_field("last_payload", got.last_payload, want.last_payload);
      case (want.result_kind)
        wavhp_pkg::KIND_HEADER: header_seen++;
        wavhp_pkg::KIND_ERROR:  error_seen++;
        default:                payload_seen++;
      endcase
    end
  endtask

  // Stall the result side at random and check every transaction taken at this edge
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && result_valid && result_ready) compare_result(result_item);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one byte, idling first at random; hold valid and payload until taken.
  // Leave valid high on return so back-to-back bytes see no bubble.
  task automatic send_byte(input wavhp_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= item;
    do @(posedge clk); while (!byte_ready);
    parse_wave_byte(item);
  endtask

  // Send the assembled file, flagging its first byte as a restart if asked, and empty it
  task automatic send_file(input bit with_start);
    wavhp_pkg::in_t item;
    foreach (file_bytes[k]) begin
      item.in_byte       = file_bytes[k];
      item.start_of_file = with_start && (k == 0);
      send_byte(item);
    end
    file_bytes.delete();
    files_sent++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic add_tag(input logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endtask

  task automatic add_u32(input logic [31:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[23:16]);
    file_bytes.push_back(v[31:24]);
  endtask

  task automatic add_bytes(input int n);
    repeat (n) file_bytes.push_back(pick_byte());
  endtask

  task automatic add_riff_head(input logic [31:0] riff_tag, input logic [31:0] wave_tag);
    add_tag(riff_tag);
    add_u32($urandom());
    add_tag(wave_tag);
  endtask

  task automatic add_chunk(input logic [31:0] id, input logic [31:0] len, input int body);
    add_tag(id);
    add_u32(len);
    add_bytes(body);
  endtask

  // Everyday stereo 16-bit 44.1 kHz fmt chunk
  task automatic add_cd_fmt();
    add_tag(wavhp_pkg::TAG_FMT);
    add_u32(wavhp_pkg::FMT_BASE_LEN);
    add_u32(32'h0002_0001);
    add_u32(32'd44100);
    add_u32(32'd176400);
    add_u32(32'h0010_0004);
  endtask

  // Well-formed file with random chunk layout and content; now and then a broken one
  task automatic add_random_wave();
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] id;
    int          chunk_len;
    int          fmt_len;
    int          data_len;
    int          cut;
    riff_tag = wavhp_pkg::TAG_RIFF;
    wave_tag = wavhp_pkg::TAG_WAVE;
    case ($urandom_range(24))
      0: riff_tag ^= 32'h1 << $urandom_range(31);
      1: wave_tag ^= 32'h1 << $urandom_range(31);
      default: ;
    endcase
    add_riff_head(riff_tag, wave_tag);
    if (riff_tag != wavhp_pkg::TAG_RIFF || wave_tag != wavhp_pkg::TAG_WAVE) begin
      add_bytes($urandom_range(0, 6));
      return;
    end
    // chunks ahead of fmt, a stray data chunk among them now and then
    repeat ($urandom_range(2)) begin
      id = ($urandom_range(3) == 0) ? wavhp_pkg::TAG_DATA : $urandom();
      if (id == wavhp_pkg::TAG_FMT) id ^= 32'h1;
      chunk_len = $urandom_range(9);
      add_chunk(id, 32'(chunk_len), chunk_len);
    end
    case ($urandom_range(5))
      0:       fmt_len = $urandom_range(15);
      1:       fmt_len = 16 + $urandom_range(1, 12);
      2:       fmt_len = 18;
      default: fmt_len = 16;
    endcase
    add_chunk(wavhp_pkg::TAG_FMT, 32'(fmt_len), 16 + ((fmt_len > 16) ? fmt_len - 16 : 0));
    // chunks between fmt and data, now and then a repeated fmt
    repeat ($urandom_range(2)) begin
      id = ($urandom_range(3) == 0) ? wavhp_pkg::TAG_FMT : $urandom();
      if (id == wavhp_pkg::TAG_DATA) id ^= 32'h1;
      chunk_len = $urandom_range(9);
      add_chunk(id, 32'(chunk_len), chunk_len);
    end
    data_len = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(24);
    add_chunk(wavhp_pkg::TAG_DATA, 32'(data_len), data_len);
    if ($urandom_range(11) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      file_bytes = file_bytes[0:cut-1];
    end
    if ($urandom_range(5) == 0) add_bytes($urandom_range(1, 3));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Parse from the reset state with no restart flag, then ignore bytes past the payload
  task automatic test_plain_file();
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_cd_fmt();
    add_tag(wavhp_pkg::TAG_DATA);
    add_u32(32'd3);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h5A);
    add_bytes(2);
    send_file(1'b0);
  endtask

  // All-ones fmt fields with one payload byte, then all-zero fields with an empty data chunk
  task automatic test_field_extremes();
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_tag(wavhp_pkg::TAG_FMT);
    add_u32(wavhp_pkg::FMT_BASE_LEN);
    repeat (4) add_u32('1);
    add_tag(wavhp_pkg::TAG_DATA);
    add_u32(32'd1);
    file_bytes.push_back(8'hFF);
    send_file(1'b1);
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_tag(wavhp_pkg::TAG_FMT);
    add_u32(wavhp_pkg::FMT_BASE_LEN);
    repeat (4) add_u32('0);
    add_chunk(wavhp_pkg::TAG_DATA, 32'd0, 3);
    send_file(1'b1);
  endtask

  // Bad RIFF tag, then a good RIFF tag followed by a bad WAVE tag
  task automatic test_bad_tags();
    add_riff_head(TAG_RIFX, wavhp_pkg::TAG_WAVE);
    send_file(1'b1);
    add_riff_head(wavhp_pkg::TAG_RIFF, TAG_WAVF);
    add_bytes(4);
    send_file(1'b1);
  endtask

  // Odd-sized chunk, data ahead of fmt, long fmt, repeated fmt, empty chunk
  task automatic test_chunk_skipping();
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_chunk(TAG_LIST, 32'd3, 3);
    add_chunk(wavhp_pkg::TAG_DATA, 32'd2, 2);
    add_chunk(wavhp_pkg::TAG_FMT, 32'd20, 20);
    add_chunk(wavhp_pkg::TAG_FMT, wavhp_pkg::FMT_BASE_LEN, 16);
    add_chunk(TAG_JUNK, 32'd0, 0);
    add_chunk(wavhp_pkg::TAG_DATA, 32'd4, 4);
    send_file(1'b1);
  endtask

  // Restart mid-skip and mid-payload; short fmt still takes sixteen bytes
  task automatic test_restart();
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_chunk(TAG_JUNK, '1, 5);
    send_file(1'b1);
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_chunk(wavhp_pkg::TAG_FMT, 32'd5, 16);
    add_chunk(wavhp_pkg::TAG_DATA, '1, 4);
    send_file(1'b1);
    add_riff_head(wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE);
    add_cd_fmt();
    add_chunk(wavhp_pkg::TAG_DATA, 32'd2, 2);
    send_file(1'b1);
  endtask

  // Random files under one idling pattern; a tenth of the time, send noise with stray restarts
  task automatic test_random_files(input int idle_pct, input int stall_in_pct, input int quota);
    wavhp_pkg::in_t item;
    int             target;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    target        = bytes_parsed + quota;
    while (bytes_parsed < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 16)) begin
          item.in_byte       = 8'($urandom());
          item.start_of_file = ($urandom_range(4) == 0);
          send_byte(item);
        end
      end else begin
        add_random_wave();
        send_file(1'b1);
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    byte_valid     = 1'b0;
    byte_item      = '0;
    result_ready   = 1'b0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    bytes_parsed   = 0;
    files_sent     = 0;
    header_seen    = 0;
    error_seen     = 0;
    payload_seen   = 0;
    clear_parser();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_plain_file();
    test_field_extremes();
    test_bad_tags();
    test_chunk_skipping();
    test_restart();

    test_random_files(0, 0, 200);
    test_random_files(82, 0, 200);
    test_random_files(0, 82, 200);
    test_random_files(17, 17, 200);

    // Drop valid, release the result side and drain
    byte_valid <= 1'b0;
    stall_pct = 0;
    while (parsed_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d files (%0d parsed bytes) over %0d cycles", files_sent, bytes_parsed,
             cycle_count);
    $display("Checked %0d header, %0d error and %0d payload results; %0d mismatches",
             header_seen, error_seen, payload_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wavhp_pkg.sv
rtl/wavhp_in_stage.sv
rtl/wavhp_parser.sv
rtl/wavhp_out_stage.sv
rtl/wav_header_parser_top.sv
tb/wav_header_parser_top_tb.sv
